// ----- rtl/core/htd_pkg.sv -----
// Shared types, codes and helper functions of the texel decoder.
package htd_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QAW           = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    FMT_NONE   = 3'd0,
    FMT_A3I5   = 3'd1,
    FMT_2BPP   = 3'd2,
    FMT_4BPP   = 3'd3,
    FMT_8BPP   = 3'd4,
    FMT_BLOCK  = 3'd5,
    FMT_A5I3   = 3'd6,
    FMT_DIRECT = 3'd7
  } fmt_e;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_DECODE    = 1'b1
  } op_e;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_FIRST_TRANSP = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    MODE_THREE_TRANSP = 2'd0,
    MODE_AVG_TRANSP   = 2'd1,
    MODE_FOUR         = 2'd2,
    MODE_BLEND        = 2'd3
  } blk_mode_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  palette_index;
    logic [14:0] palette_color;
    logic [31:0] texel_data;
    logic [15:0] block_palette_word;
  } htd_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } htd_out_t;

  // One classified word, as handed from the front to the back.
  typedef struct packed {
    logic        is_write;
    fmt_e        fmt;
    logic        first_transp;
    logic [7:0]  index;
    logic [14:0] color;
    logic [31:0] data;
    logic [15:0] pw;
  } htd_cmd_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen3(input logic [2:0] v);
    widen3 = {v, v, v[2:1]};
  endfunction

  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    avg8 = s[8:1];
  endfunction

  // (5a + 3b) >> 3
  function automatic logic [7:0] blend53(input logic [7:0] a, input logic [7:0] b);
    logic [10:0] s;
    s = {1'b0, a, 2'b00} + {3'b000, a} + {2'b00, b, 1'b0} + {3'b000, b};
    blend53 = s[10:3];
  endfunction

endpackage

// ----- rtl/core/handheld_texture_texel_decoder.sv -----
// Top level of the texel decoder: front end, command queue and back end.
//
//   channel  direction  handshake                    word
//   in       input      in_valid_i / in_stall_o      htd_in_t: palette write or texel word
//   out      output     out_valid_o / out_stall_i    htd_out_t: one RGBA8 pixel
//   cfg      input      cfg_we_i, cfg_idx_i          format, first-color transparency
//
// Steps: the back end issues one step per cycle from a single palette read
// port while the color stage can take it; a palette write is one step, A3I5,
// 8bpp, A5I3 and direct one pixel, 4bpp four, 2bpp eight, and a compressed
// block four palette fetches, then 16 pixels. The first pixel passes the queue
// write, the issue register and the output register.
// Reset: format 4bpp, first-color transparency off; the palette RAM is not
// cleared and must be written before use.
// Stalls: a 2-word queue and the output register decouple the sides; input
// stalls only while the queue is full.
module handheld_texture_texel_decoder import htd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  htd_in_t    in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output htd_out_t   out_word_o
);

  logic     q_full, q_push, q_pop, q_valid;
  htd_cmd_t q_cmd, q_head;

  // Front: hold config, classify each word, drop decode words with no format.
  htd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  // Queue: keep palette writes and decodes in order so reads see prior writes.
  htd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // Back: one step of the head word per cycle unless stalled, into the output register.
  htd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- rtl/core/htd_front.sv -----
// Front end: configuration registers, word acceptance and classification.
module htd_front import htd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  htd_in_t  in_word_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output htd_cmd_t q_cmd_o
);

  fmt_e fmt_q;
  logic first_transp_q;
  logic drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q          <= FMT_4BPP;
      first_transp_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_FORMAT:       fmt_q <= fmt_e'(cfg_wdata_i);
        REG_FIRST_TRANSP: first_transp_q <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  // A decode word with no format set produces nothing: take it and drop it.
  assign drop = (op_e'(in_word_i.op) == OP_DECODE) && (fmt_q == FMT_NONE);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && !drop;

  always_comb begin
    q_cmd_o.is_write     = (op_e'(in_word_i.op) == OP_PAL_WRITE);
    q_cmd_o.fmt          = fmt_q;
    q_cmd_o.first_transp = first_transp_q;
    q_cmd_o.index        = in_word_i.palette_index;
    q_cmd_o.color        = in_word_i.palette_color;
    q_cmd_o.data         = in_word_i.texel_data;
    q_cmd_o.pw           = in_word_i.block_palette_word;
  end

endmodule

// ----- rtl/core/htd_queue.sv -----
// Short command queue between front and back.
module htd_queue import htd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  htd_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output htd_cmd_t head_o
);

  htd_cmd_t         mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     count_q;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/htd_back.sv -----
// Back end: palette RAM, per-pixel sequencer, block color table, output register.
module htd_back import htd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  htd_cmd_t q_head_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output htd_out_t out_word_o
);

  typedef enum logic [1:0] {
    K_LOAD   = 2'd0,
    K_PAL    = 2'd1,
    K_DIRECT = 2'd2,
    K_BLOCK  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  slot;
    logic [1:0]  mode;
    logic [7:0]  alpha;
    logic [14:0] color;
    logic        last;
  } s1_t;

  logic [14:0]       pal_mem [PALETTE_DEPTH];
  logic [14:0]       rdata_q;
  logic [4:0]        k_q;
  logic              s1_valid_q;
  s1_t               s1_q, s1_d;
  logic [31:0]       ch_q [4];
  logic              out_valid_q;
  htd_out_t          out_q;

  logic              out_free, s1_adv, issue_ready, issue_go, last_step, need_rd;
  logic [4:0]        nsteps_m1;
  logic [4:0]        kb;
  logic [1:0]        idx2;
  logic [3:0]        idx4;
  logic [PAL_AW-1:0] raddr;
  logic [14:0]       col;
  logic [31:0]       wcol, ld_word;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && ((s1_q.kind == K_LOAD) || out_free);
  assign issue_ready = !s1_valid_q || s1_adv;
  assign issue_go    = q_valid_i && issue_ready;
  assign last_step   = (k_q == nsteps_m1);
  assign q_pop_o     = issue_go && last_step;

  // Issue stage: one step of the head word per cycle unless the color stage is held.
  always_comb begin
    nsteps_m1 = 5'd0;
    if (!q_head_i.is_write) begin
      case (q_head_i.fmt)
        FMT_2BPP:  nsteps_m1 = 5'd7;
        FMT_4BPP:  nsteps_m1 = 5'd3;
        FMT_BLOCK: nsteps_m1 = 5'd19;
        default:   nsteps_m1 = 5'd0;
      endcase
    end

    kb   = k_q - 5'd4;
    idx2 = q_head_i.data[{k_q[2:0], 1'b0} +: 2];
    idx4 = q_head_i.data[{k_q[1:0], 2'b00} +: 4];

    need_rd    = 1'b0;
    raddr      = '0;
    s1_d.kind  = K_PAL;
    s1_d.slot  = 2'd0;
    s1_d.mode  = q_head_i.pw[15:14];
    s1_d.alpha = 8'hFF;
    s1_d.color = q_head_i.data[14:0];
    s1_d.last  = last_step;

    case (q_head_i.fmt)
      FMT_A3I5: begin
        need_rd    = 1'b1;
        raddr      = PAL_AW'(q_head_i.data[4:0]);
        s1_d.alpha = widen3(q_head_i.data[7:5]);
      end
      FMT_2BPP: begin
        need_rd    = 1'b1;
        raddr      = PAL_AW'(idx2);
        s1_d.alpha = (idx2 == 2'd0 && q_head_i.first_transp) ? 8'h00 : 8'hFF;
      end
      FMT_4BPP: begin
        need_rd    = 1'b1;
        raddr      = PAL_AW'(idx4);
        s1_d.alpha = (idx4 == 4'd0 && q_head_i.first_transp) ? 8'h00 : 8'hFF;
      end
      FMT_8BPP: begin
        need_rd    = 1'b1;
        raddr      = PAL_AW'(q_head_i.data[7:0]);
        s1_d.alpha = (q_head_i.data[7:0] == 8'd0 && q_head_i.first_transp) ? 8'h00 : 8'hFF;
      end
      FMT_A5I3: begin
        need_rd    = 1'b1;
        raddr      = PAL_AW'(q_head_i.data[2:0]);
        s1_d.alpha = widen5(q_head_i.data[7:3]);
      end
      FMT_DIRECT: begin
        s1_d.kind = K_DIRECT;
      end
      FMT_BLOCK: begin
        // First four steps fetch the block's colors, then one pixel per step.
        if (k_q < 5'd4) begin
          need_rd   = 1'b1;
          raddr     = PAL_AW'(q_head_i.pw[13:0] + 14'(k_q[1:0]));
          s1_d.kind = K_LOAD;
          s1_d.slot = k_q[1:0];
        end else begin
          s1_d.kind = K_BLOCK;
          s1_d.slot = q_head_i.data[{kb[3:0], 1'b0} +: 2];
        end
      end
      default: ;
    endcase

    if (q_head_i.is_write) begin
      need_rd = 1'b0;
    end
  end

  // Palette RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (issue_go && q_head_i.is_write) begin
      pal_mem[PAL_AW'(q_head_i.index)] <= q_head_i.color;
    end
    if (issue_go && need_rd) begin
      rdata_q <= pal_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (issue_go) begin
        k_q <= last_step ? 5'd0 : k_q + 5'd1;
      end
      if (issue_ready) begin
        s1_valid_q <= issue_go && !q_head_i.is_write;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_ready && issue_go) begin
      s1_q <= s1_d;
    end
  end

  // Color stage: widen the fetched color, build block table entries.
  always_comb begin
    col  = (s1_q.kind == K_DIRECT) ? s1_q.color : rdata_q;
    wcol = {widen5(col[4:0]), widen5(col[9:5]), widen5(col[14:10]), 8'hFF};
    ld_word = wcol;
    case (s1_q.slot)
      2'd2: begin
        case (blk_mode_e'(s1_q.mode))
          MODE_AVG_TRANSP: ld_word = {avg8(ch_q[0][31:24], ch_q[1][31:24]),
                                      avg8(ch_q[0][23:16], ch_q[1][23:16]),
                                      avg8(ch_q[0][15:8],  ch_q[1][15:8]), 8'hFF};
          MODE_BLEND:      ld_word = {blend53(ch_q[0][31:24], ch_q[1][31:24]),
                                      blend53(ch_q[0][23:16], ch_q[1][23:16]),
                                      blend53(ch_q[0][15:8],  ch_q[1][15:8]), 8'hFF};
          default:         ld_word = wcol;
        endcase
      end
      2'd3: begin
        case (blk_mode_e'(s1_q.mode))
          MODE_THREE_TRANSP,
          MODE_AVG_TRANSP: ld_word = 32'd0;
          MODE_BLEND:      ld_word = {blend53(ch_q[1][31:24], ch_q[0][31:24]),
                                      blend53(ch_q[1][23:16], ch_q[0][23:16]),
                                      blend53(ch_q[1][15:8],  ch_q[0][15:8]), 8'hFF};
          default:         ld_word = wcol;
        endcase
      end
      default: ld_word = wcol;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.kind == K_LOAD) begin
      ch_q[s1_q.slot] <= ld_word;
    end
    if (s1_adv && s1_q.kind != K_LOAD) begin
      if (s1_q.kind == K_BLOCK) begin
        out_q <= {ch_q[s1_q.slot], s1_q.last};
      end else begin
        out_q <= {wcol[31:8], s1_q.alpha, s1_q.last};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && (s1_q.kind != K_LOAD);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> $stable(rdata_q))
    else $error("palette read data changed under a held color stage");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 5'd19)
    else $error("step counter out of range");

  a_head_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 5'd0) |-> q_valid_i)
    else $error("partly issued word left the queue");

  a_load_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.kind == K_LOAD) |-> s1_adv)
    else $error("block color fetch stalled in color stage");

endmodule

// ----- tb/htd_tb_pkg.sv -----
// Pixel predictor and scoreboard class for the texel decoder testbench.
package htd_tb_pkg;
  import htd_pkg::*;

  class texel_pixel_scoreboard;
    logic [14:0] palette_mirror [PALETTE_DEPTH];
    fmt_e        texel_fmt;
    logic        zero_transp;
    htd_out_t    pending_pixels [$];
    htd_out_t    word_pixels [$];
    int unsigned mismatches;

    function new();
      texel_fmt   = FMT_4BPP;
      zero_transp = 1'b0;
      mismatches  = 0;
      foreach (palette_mirror[i]) palette_mirror[i] = '0;
    endfunction

    function void set_register(reg_e r, logic [2:0] v);
      if (r == REG_FORMAT) begin
        texel_fmt = fmt_e'(v);
      end else begin
        zero_transp = v[0];
      end
    endfunction

    function logic [7:0] expand5(logic [4:0] v);
      return (8'(v) << 3) | 8'(v >> 2);
    endfunction

    function logic [7:0] expand3(logic [2:0] v);
      return (8'(v) << 5) | (8'(v) << 2) | 8'(v >> 1);
    endfunction

    function logic [14:0] lookup(int idx);
      return palette_mirror[idx % PALETTE_DEPTH];
    endfunction

    function void add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      htd_out_t p;
      p.red        = r;
      p.green      = g;
      p.blue       = b;
      p.alpha      = a;
      p.last_pixel = 1'b0;
      word_pixels.insert(word_pixels.size(), p);
    endfunction

    function void add_color(logic [14:0] c, logic [7:0] a);
      add_pixel(expand5(c[4:0]), expand5(c[9:5]), expand5(c[14:10]), a);
    endfunction

    function void add_indexed(int idx);
      add_color(lookup(idx), (idx == 0 && zero_transp) ? 8'h00 : 8'hFF);
    endfunction

    // 4x4 block: two fetched colors, two more fetched or derived by mode.
    function void expand_block(logic [31:0] data, logic [15:0] pw);
      blk_mode_e   mode;
      int          base;
      int          a;
      int          b;
      int          v;
      logic [14:0] c;
      logic [7:0]  chan [4][4];
      logic [1:0]  code;
      mode = blk_mode_e'(pw[15:14]);
      base = int'(pw[13:0]);
      for (int i = 0; i < 2; i++) begin
        c = lookup(base + i);
        for (int s = 0; s < 3; s++) chan[i][s] = expand5(c[5*s +: 5]);
        chan[i][3] = 8'hFF;
      end
      for (int i = 2; i < 4; i++) begin
        c = lookup(base + i);
        for (int s = 0; s < 3; s++) begin
          a = chan[0][s];
          b = chan[1][s];
          case (mode)
            MODE_AVG_TRANSP:   v = (i == 2) ? (a + b) >> 1 : 0;
            MODE_BLEND:        v = (i == 2) ? (5 * a + 3 * b) >> 3 : (3 * a + 5 * b) >> 3;
            MODE_THREE_TRANSP: v = (i == 3) ? 0 : int'(expand5(c[5*s +: 5]));
            default:           v = int'(expand5(c[5*s +: 5]));
          endcase
          chan[i][s] = 8'(v);
        end
        chan[i][3] = (i == 3 && (mode == MODE_THREE_TRANSP || mode == MODE_AVG_TRANSP))
                     ? 8'h00 : 8'hFF;
      end
      for (int k = 0; k < 16; k++) begin
        code = data[2*k +: 2];
        add_pixel(chan[code][0], chan[code][1], chan[code][2], chan[code][3]);
      end
    endfunction

    function void note_word(htd_in_t w);
      if (w.op == OP_PAL_WRITE) begin
        palette_mirror[w.palette_index % PALETTE_DEPTH] = w.palette_color;
      end else begin
        word_pixels.delete();
        case (texel_fmt)
          FMT_A3I5:   add_color(lookup(w.texel_data[4:0]), expand3(w.texel_data[7:5]));
          FMT_2BPP:   for (int k = 0; k < 8; k++) add_indexed(w.texel_data[2*k +: 2]);
          FMT_4BPP:   for (int k = 0; k < 4; k++) add_indexed(w.texel_data[4*k +: 4]);
          FMT_8BPP:   add_indexed(w.texel_data[7:0]);
          FMT_BLOCK:  expand_block(w.texel_data, w.block_palette_word);
          FMT_A5I3:   add_color(lookup(w.texel_data[2:0]), expand5(w.texel_data[7:3]));
          FMT_DIRECT: add_color(w.texel_data[14:0], 8'hFF);
          default: ;
        endcase
        if (word_pixels.size() != 0) begin
          word_pixels[word_pixels.size() - 1].last_pixel = 1'b1;
          pending_pixels = {pending_pixels, word_pixels};
        end
      end
    endfunction

    task report(string msg);
      $display("[%0t] pixel mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_pixel(htd_out_t got);
      htd_out_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel r%0d g%0d b%0d a%0d last%0d",
                         got.red, got.green, got.blue, got.alpha, got.last_pixel));
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.last_pixel !== want.last_pixel) begin
          report($sformatf("got r%0d g%0d b%0d a%0d last%0d, want r%0d g%0d b%0d a%0d last%0d",
                           got.red, got.green, got.blue, got.alpha, got.last_pixel,
                           want.red, want.green, want.blue, want.alpha, want.last_pixel));
        end
      end
    endtask
  endclass

endpackage

// ----- tb/testbench.sv -----
// Self-checking testbench of the texel decoder: directed and random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htd_pkg::*;
  import htd_tb_pkg::*;

  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned PHASE_WORDS     = 32;
  localparam int unsigned DRAIN_CYCLES    = 32;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_idx   = REG_FORMAT;
  logic [2:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  htd_in_t    in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  htd_out_t   out_word;

  texel_pixel_scoreboard pix_sb;

  // Entries the stimulus has written so far; decodes only touch these.
  bit pal_written [PALETTE_DEPTH];
  bit steady_sender = 1'b0;
  bit hold_request  = 1'b0;

  fmt_e phase_formats [RANDOM_PHASES] = '{FMT_BLOCK, FMT_2BPP, FMT_8BPP, FMT_4BPP,
                                          FMT_A3I5, FMT_BLOCK, FMT_A5I3, FMT_DIRECT,
                                          FMT_8BPP, FMT_BLOCK, FMT_2BPP, FMT_4BPP};

  handheld_texture_texel_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic htd_in_t make_write(logic [7:0] idx, logic [14:0] color);
    htd_in_t w;
    w.op                 = OP_PAL_WRITE;
    w.palette_index      = idx;
    w.palette_color      = color;
    w.texel_data         = $urandom;
    w.block_palette_word = 16'($urandom);
    pal_written[idx]     = 1'b1;
    return w;
  endfunction

  function automatic htd_in_t make_decode(logic [31:0] data, logic [15:0] pw);
    htd_in_t w;
    w.op                 = OP_DECODE;
    w.palette_index      = 8'($urandom);
    w.palette_color      = 15'($urandom);
    w.texel_data         = data;
    w.block_palette_word = pw;
    return w;
  endfunction

  // Keep the wanted index if it is loaded, else retry below span, else entry 0.
  function automatic logic [7:0] written_index(int unsigned span, logic [7:0] want);
    logic [7:0] pick;
    if (pal_written[want]) return want;
    for (int t = 0; t < 16; t++) begin
      pick = 8'($urandom_range(0, span - 1));
      if (pal_written[pick]) return pick;
    end
    return 8'd0;
  endfunction

  // A block reads four entries from its base, wrapping past the top.
  function automatic logic [7:0] legal_base(logic [7:0] b);
    logic [7:0] pick;
    pick = b;
    for (int t = 0; t < 16; t++) begin
      if (pal_written[pick] && pal_written[pick + 8'd1] &&
          pal_written[pick + 8'd2] && pal_written[pick + 8'd3]) return pick;
      pick = 8'($urandom);
    end
    return 8'd0;
  endfunction

  function automatic htd_in_t random_item(fmt_e f);
    htd_in_t w;
    w = make_decode($urandom, 16'($urandom));
    if ($urandom_range(0, 99) < 30) begin
      // bias half the writes onto the low entries the small formats use
      w = make_write($urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom),
                     15'($urandom));
    end else begin
      case (f)
        FMT_A3I5:  w.texel_data[4:0] = 5'(written_index(32, 8'(w.texel_data[4:0])));
        FMT_4BPP:  for (int k = 0; k < 4; k++)
                     w.texel_data[4*k +: 4] = 4'(written_index(16, 8'(w.texel_data[4*k +: 4])));
        FMT_8BPP:  w.texel_data[7:0] = written_index(256, w.texel_data[7:0]);
        FMT_BLOCK: w.block_palette_word[7:0] = legal_base(w.block_palette_word[7:0]);
        FMT_A5I3:  w.texel_data[2:0] = 3'(written_index(8, 8'(w.texel_data[2:0])));
        default: ;
      endcase
    end
    return w;
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // afterwards so a back-to-back word needs no drop in between.
  task automatic push_word(htd_in_t w);
    int unsigned gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pix_sb.note_word(w);
  endtask

  // Drop valid, wait for every predicted pixel, then let the back end go quiet
  // (palette writes and format-zero words leave no pixel to wait on).
  task automatic settle();
    in_valid <= 1'b0;
    while (pix_sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; only called when idle.
  task automatic write_setting(fmt_e f, logic t);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FORMAT;
    cfg_wdata <= f;
    @(posedge clk);
    pix_sb.set_register(REG_FORMAT, f);
    cfg_idx   <= REG_FIRST_TRANSP;
    cfg_wdata <= {2'($urandom), t};
    @(posedge clk);
    pix_sb.set_register(REG_FIRST_TRANSP, {2'b00, t});
    cfg_we    <= 1'b0;
  endtask

  task automatic next_setting(fmt_e f, logic t);
    settle();
    write_setting(f, t);
  endtask

  // Check every pixel the block hands over against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pix_sb.check_pixel(out_word);
  end

  // Receiver: stall runs, open stretches, and one long hold on request.
  initial begin : pixel_sink
    int unsigned n;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    fmt_e fmt;
    pix_sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load the entries the directed words use: both ends of the index range,
    // all-ones and all-zeros colors, alternating bit patterns.
    push_word(make_write(8'd0, 15'h7FFF));
    push_word(make_write(8'd1, 15'h0000));
    push_word(make_write(8'd2, 15'h5555));
    push_word(make_write(8'd3, 15'h2AAA));
    push_word(make_write(8'd255, 15'($urandom)));
    push_word(make_write(8'd31, 15'($urandom)));
    push_word(make_write(8'd7, 15'($urandom)));
    push_word(make_write(8'd15, 15'($urandom)));

    // Reset setting: 4bpp with index zero opaque.
    push_word(make_decode(32'h0000_3210, 16'($urandom)));
    push_word(make_decode(32'hFFFF_F70F, 16'($urandom)));

    next_setting(FMT_2BPP, 1'b1);
    push_word(make_decode(32'hFFFF_1B00, 16'($urandom)));

    // Lowest format code that decodes; top index with full alpha, then index zero clear.
    next_setting(FMT_A3I5, 1'b1);
    push_word(make_decode(32'h0000_00FF, 16'($urandom)));
    push_word(make_decode(32'h0000_0000, 16'($urandom)));

    next_setting(FMT_A5I3, 1'b0);
    push_word(make_decode(32'h0000_00FF, 16'($urandom)));
    push_word(make_decode(32'h0000_0000, 16'($urandom)));

    next_setting(FMT_8BPP, 1'b1);
    push_word(make_decode(32'h0000_00FF, 16'($urandom)));
    push_word(make_decode(32'h0000_0000, 16'($urandom)));

    next_setting(FMT_DIRECT, 1'b0);
    push_word(make_decode(32'hFFFF_FFFF, 16'($urandom)));
    push_word(make_decode(32'h0000_0000, 16'($urandom)));

    // Every block mode with all four codes; a top base wraps to entry zero.
    next_setting(FMT_BLOCK, 1'b0);
    push_word(make_decode(32'hE4E4_E4E4, {MODE_THREE_TRANSP, 14'h0000}));
    push_word(make_decode(32'hE4E4_E4E4, {MODE_AVG_TRANSP, 14'h0000}));
    push_word(make_decode(32'hE4E4_E4E4, {MODE_FOUR, 14'h3FFF}));
    push_word(make_decode(32'hE4E4_E4E4, {MODE_BLEND, 14'h0000}));
    push_word(make_decode(32'hFFFF_FFFF, {MODE_BLEND, 14'h3FFF}));

    // Format zero drops the word without a pixel.
    next_setting(FMT_NONE, 1'b0);
    push_word(make_decode($urandom, 16'($urandom)));

    // Random phases. The first one runs back to back while the receiver holds
    // off, so the queue fills and the input stalls.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      fmt = phase_formats[p];
      steady_sender = (p == 0) || ($urandom_range(0, 3) == 0);
      next_setting(fmt, 1'($urandom_range(0, 1)));
      if (p == 0) hold_request = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) push_word(random_item(fmt));
    end

    settle();
    if (pix_sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
